// File: design/ovle_pkg.sv
// Shared constants, codes and beat types for the ordered value list engine.
package ovle_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_QUERY     = 3'd2,
      OP_REM_FIRST = 3'd3,
      OP_REM_ALL   = 3'd4,
      OP_READ_FWD  = 3'd5,
      OP_READ_BWD  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]                op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] elem_value;
      logic                      elem_valid;
      logic                      found;
      logic [5:0]                entry_count;
      logic [1:0]                status;
      logic                      last;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHR,
      CELL_SHL,
      CELL_WRITE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type              cmd;
      logic [IDX_W-1:0]          tgt;
      logic                      append;
      logic signed [VALUE_W-1:0] data;
   } cell_ctl_type;

endpackage

// File: design/ovle_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbours.
module ovle_cell (
   input  logic                               clock,
   input  ovle_pkg::cell_ctl_type             ctl,
   input  logic [ovle_pkg::IDX_W-1:0]         cell_index,
   input  logic signed [ovle_pkg::VALUE_W-1:0] left_value,
   input  logic signed [ovle_pkg::VALUE_W-1:0] right_value,
   input  logic signed [ovle_pkg::VALUE_W-1:0] key,
   input  logic [ovle_pkg::CNT_W-1:0]         count,
   output logic signed [ovle_pkg::VALUE_W-1:0] value,
   output logic                               match
);

   logic signed [ovle_pkg::VALUE_W-1:0] value_ff;
   logic signed [ovle_pkg::VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.cmd)
         ovle_pkg::CELL_HOLD: value_in = value_ff;
         ovle_pkg::CELL_SHR:  value_in = left_value;
         ovle_pkg::CELL_SHL: begin
            // the tail slot picks up the rotated head, the rest move forward
            if (ctl.append && (cell_index == ctl.tgt)) value_in = ctl.data;
            else value_in = right_value;
         end
         ovle_pkg::CELL_WRITE: begin
            if (cell_index == ctl.tgt) value_in = ctl.data;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (value_ff == key) && (ovle_pkg::CNT_W'(cell_index) < count);

endmodule

// File: design/ovle_chain.sv
// Row of list cells with neighbour wiring, head and tail taps and the presence reduction.
module ovle_chain (
   input  logic                                clock,
   input  ovle_pkg::cell_ctl_type              ctl,
   input  logic signed [ovle_pkg::VALUE_W-1:0] key,
   input  logic [ovle_pkg::CNT_W-1:0]          count,
   input  logic [ovle_pkg::IDX_W-1:0]          tail_idx,
   output logic signed [ovle_pkg::VALUE_W-1:0] head_value,
   output logic signed [ovle_pkg::VALUE_W-1:0] tail_value,
   output logic                                any_match
);

   logic signed [ovle_pkg::VALUE_W-1:0] cell_value [ovle_pkg::CAPACITY];
   logic [ovle_pkg::CAPACITY-1:0]       cell_match;

   for (genvar i = 0; i < ovle_pkg::CAPACITY; i++) begin : g_cell
      logic signed [ovle_pkg::VALUE_W-1:0] left_value;
      logic signed [ovle_pkg::VALUE_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = ctl.data;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == ovle_pkg::CAPACITY - 1) begin : g_final
         assign right_value = cell_value[i];
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      ovle_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_index  (ovle_pkg::IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .key         (key),
         .count       (count),
         .value       (cell_value[i]),
         .match       (cell_match[i])
      );
   end

   assign head_value = cell_value[0];
   assign tail_value = cell_value[tail_idx];
   assign any_match  = |cell_match;

endmodule

// File: design/ordered_value_list_engine.sv
// Top level of the ordered value list engine: request decode, sequencer and result register.
//
// Usage
//   Requests: drive req_data (op, value) and raise start; a beat is taken at
//   the rising edge where start is high and busy is low.
//   Results: every result beat sits on rsp_data for exactly one cycle with
//   rsp_valid high. The receiver cannot stall, so nothing is held back.
// Sequencing and throughput
//   Insert, query, no-op, a removal that finds nothing and a readout of an
//   empty list give one result the cycle after the request; busy stays low,
//   so such requests are taken every cycle.
//   A removal rotates the whole list once through the cell chain, one entry
//   per cycle, with busy high while it rotates, then gives the single
//   result.
//   A readout rotates the list once, forward as a removal does, backward the
//   other way, and shows one entry per cycle from the first rotation step:
//   N beats back to back, last marked.
// Reset
//   reset (synchronous, active high) empties the list and drops any
//   sequence under way. Cell contents are not cleared; the entry count
//   alone decides what is live.
module ordered_value_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ovle_pkg::req_type req_data,
   output logic              rsp_valid,
   output ovle_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROTATE,
      S_BACK
   } state_type;

   state_type                           state_ff, state_in;
   logic [ovle_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [ovle_pkg::CNT_W-1:0]          remaining_ff, remaining_in;
   logic signed [ovle_pkg::VALUE_W-1:0] key_ff, key_in;
   logic                                remove_all_ff, remove_all_in;
   logic                                dropped_ff, dropped_in;
   logic                                reading_ff, reading_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ovle_pkg::rsp_type                   rsp_ff, rsp_in;

   ovle_pkg::cell_ctl_type              ctl;
   logic signed [ovle_pkg::VALUE_W-1:0] chain_key;
   logic signed [ovle_pkg::VALUE_W-1:0] head_value;
   logic signed [ovle_pkg::VALUE_W-1:0] tail_value;
   logic [ovle_pkg::IDX_W-1:0]          tail_idx;
   logic [ovle_pkg::CNT_W-1:0]          count_dec;
   logic [ovle_pkg::CNT_W-1:0]          count_inc;
   logic                                any_match;
   logic                                accept;
   logic                                is_full;
   logic                                drop;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign is_full   = (count_ff == ovle_pkg::CNT_W'(ovle_pkg::CAPACITY));
   assign count_dec = count_ff - ovle_pkg::CNT_W'(1);
   assign count_inc = count_ff + ovle_pkg::CNT_W'(1);
   assign tail_idx  = count_dec[ovle_pkg::IDX_W-1:0];
   // presence is looked up against the request value only while idle
   assign chain_key = busy ? key_ff : req_data.value;

   // Drop the head when it matches and the removal still wants it; readouts keep all.
   assign drop = !reading_ff && (head_value == key_ff) && (remove_all_ff || !dropped_ff);

   ovle_chain u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .key        (chain_key),
      .count      (count_ff),
      .tail_idx   (tail_idx),
      .head_value (head_value),
      .tail_value (tail_value),
      .any_match  (any_match)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remaining_in  = remaining_ff;
      key_in        = key_ff;
      remove_all_in = remove_all_ff;
      dropped_in    = dropped_ff;
      reading_in    = reading_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      ctl.cmd    = ovle_pkg::CELL_HOLD;
      ctl.tgt    = tail_idx;
      ctl.append = 1'b0;
      ctl.data   = req_data.value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // single-beat answer unless the op below starts a sequence
               rsp_valid_in       = 1'b1;
               rsp_in.elem_value  = req_data.value;
               rsp_in.elem_valid  = 1'b0;
               rsp_in.found       = any_match;
               rsp_in.entry_count = 6'(count_ff);
               rsp_in.status      = ovle_pkg::ST_DONE;
               rsp_in.last        = 1'b1;
               key_in             = req_data.value;
               remaining_in       = count_ff;
               dropped_in         = 1'b0;
               remove_all_in      = (req_data.op == ovle_pkg::OP_REM_ALL);

               case (req_data.op)
                  ovle_pkg::OP_INS_FRONT: begin
                     if (is_full) begin
                        rsp_in.status = ovle_pkg::ST_FULL;
                     end else begin
                        // push everything one cell back, new value enters cell 0
                        ctl.cmd            = ovle_pkg::CELL_SHR;
                        count_in           = count_inc;
                        rsp_in.entry_count = 6'(count_inc);
                     end
                  end
                  ovle_pkg::OP_INS_BACK: begin
                     if (is_full) begin
                        rsp_in.status = ovle_pkg::ST_FULL;
                     end else begin
                        ctl.cmd            = ovle_pkg::CELL_WRITE;
                        ctl.tgt            = count_ff[ovle_pkg::IDX_W-1:0];
                        count_in           = count_inc;
                        rsp_in.entry_count = 6'(count_inc);
                     end
                  end
                  ovle_pkg::OP_QUERY: begin
                     rsp_in.found = any_match;
                  end
                  ovle_pkg::OP_REM_FIRST,
                  ovle_pkg::OP_REM_ALL: begin
                     if (!any_match) begin
                        rsp_in.status = ovle_pkg::ST_NOT_FOUND;
                     end else begin
                        // hold the answer until the rotation has gone round once
                        rsp_valid_in = 1'b0;
                        reading_in   = 1'b0;
                        state_in     = S_ROTATE;
                     end
                  end
                  ovle_pkg::OP_READ_FWD,
                  ovle_pkg::OP_READ_BWD: begin
                     rsp_in.found = 1'b0;
                     if (count_ff == '0) begin
                        rsp_in.elem_value = '0;
                     end else begin
                        rsp_valid_in = 1'b0;
                        reading_in   = 1'b1;
                        state_in     = (req_data.op == ovle_pkg::OP_READ_FWD) ? S_ROTATE
                                                                              : S_BACK;
                     end
                  end
                  default: begin
                     // unused code: echo the value, leave the list alone
                     rsp_in.found = 1'b0;
                  end
               endcase
            end
         end

         S_ROTATE: begin
            // Pop the head, advance the chain, append the head at the tail unless dropped.
            ctl.cmd      = ovle_pkg::CELL_SHL;
            ctl.data     = head_value;
            ctl.append   = !drop;
            remaining_in = remaining_ff - ovle_pkg::CNT_W'(1);
            if (drop) begin
               count_in   = count_dec;
               dropped_in = 1'b1;
            end
            if (reading_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.elem_value  = head_value;
               rsp_in.elem_valid  = 1'b1;
               rsp_in.found       = 1'b0;
               rsp_in.entry_count = 6'(count_ff);
               rsp_in.status      = ovle_pkg::ST_DONE;
               rsp_in.last        = (remaining_ff == ovle_pkg::CNT_W'(1));
            end
            if (remaining_ff == ovle_pkg::CNT_W'(1)) begin
               state_in = S_IDLE;
               if (!reading_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.elem_value  = key_ff;
                  rsp_in.elem_valid  = 1'b0;
                  rsp_in.found       = 1'b1;
                  rsp_in.entry_count = drop ? 6'(count_dec) : 6'(count_ff);
                  rsp_in.status      = ovle_pkg::ST_DONE;
                  rsp_in.last        = 1'b1;
               end
            end
         end

         S_BACK: begin
            // Rotate the other way: tail goes out and re-enters at cell 0.
            ctl.cmd            = ovle_pkg::CELL_SHR;
            ctl.data           = tail_value;
            remaining_in       = remaining_ff - ovle_pkg::CNT_W'(1);
            rsp_valid_in       = 1'b1;
            rsp_in.elem_value  = tail_value;
            rsp_in.elem_valid  = 1'b1;
            rsp_in.found       = 1'b0;
            rsp_in.entry_count = 6'(count_ff);
            rsp_in.status      = ovle_pkg::ST_DONE;
            rsp_in.last        = (remaining_ff == ovle_pkg::CNT_W'(1));
            if (remaining_ff == ovle_pkg::CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         remaining_ff  <= '0;
         remove_all_ff <= 1'b0;
         dropped_ff    <= 1'b0;
         reading_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remaining_ff  <= remaining_in;
         remove_all_ff <= remove_all_in;
         dropped_ff    <= dropped_in;
         reading_ff    <= reading_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload: no reset needed
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/ovle_checker.sv
// Port-level checks for the ordered value list engine, bound to the top level.
module ovle_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input ovle_pkg::rsp_type rsp_data
);

   a_idle_after_reset : assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   a_readout_unbroken : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=> rsp_valid)
      else $error("readout beats not back to back");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= 6'(ovle_pkg::CAPACITY)))
      else $error("entry count above capacity");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ovle_pkg::ST_FULL))
      |-> (rsp_data.entry_count == 6'(ovle_pkg::CAPACITY)))
      else $error("full reported below capacity");

   a_readout_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.elem_valid)
      |-> (!rsp_data.found && (rsp_data.status == ovle_pkg::ST_DONE)))
      else $error("readout beat carries found or status");

endmodule

bind ordered_value_list_engine ovle_checker u_ovle_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the ordered value list engine, with a scoreboard and a request driver.
`timescale 1ns / 1ps

module tb_top;
   import ovle_pkg::*;

   // Selector left unused by the block: it must behave as a no-op echo.
   localparam logic [2:0] OP_SPARE     = 3'd7;
   localparam int         DIRECTED_N   = 24;
   localparam int         ROUNDS       = 10;
   localparam int         ROUND_LEN    = 40;
   // Random beats from here on go out back to back, with no idling.
   localparam int         CALM_FROM    = 340;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         SETTLE_CYCLES = 40;

   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_DRAIN,
      MIX_MIXED
   } mix_type;

   // Tracks the list contents and the result beats still owed by the block.
   class list_scoreboard;
      logic signed [VALUE_W-1:0] cells[$];
      rsp_type                   owed[$];
      int unsigned               failures;

      function int unsigned pending();
         return owed.size();
      endfunction

      function void apply_request(req_type r);
         rsp_type                   beat;
         logic                      was;
         int                        i;
         int                        n;
         logic signed [VALUE_W-1:0] kept[$];
         was = 1'b0;
         for (i = 0; i < cells.size(); i++)
            if (cells[i] == r.value) was = 1'b1;
         beat.elem_value = r.value;
         beat.elem_valid = 1'b0;
         beat.found      = was;
         beat.status     = ST_DONE;
         beat.last       = 1'b1;
         case (r.op)
            OP_INS_FRONT: begin
               if (cells.size() >= CAPACITY) beat.status = ST_FULL;
               else cells.push_front(r.value);
            end
            OP_INS_BACK: begin
               if (cells.size() >= CAPACITY) beat.status = ST_FULL;
               else cells.push_back(r.value);
            end
            OP_QUERY: begin
            end
            OP_REM_FIRST: begin
               if (!was) begin
                  beat.status = ST_NOT_FOUND;
               end else begin
                  for (i = 0; i < cells.size(); i++)
                     if (cells[i] == r.value) begin
                        cells.delete(i);
                        break;
                     end
               end
            end
            OP_REM_ALL: begin
               if (!was) begin
                  beat.status = ST_NOT_FOUND;
               end else begin
                  for (i = 0; i < cells.size(); i++)
                     if (cells[i] != r.value) kept.push_back(cells[i]);
                  cells = kept;
               end
            end
            OP_READ_FWD, OP_READ_BWD: begin
               n = cells.size();
               beat.found       = 1'b0;
               beat.entry_count = 6'(n);
               if (n == 0) begin
                  beat.elem_value = '0;
                  owed.push_back(beat);
                  return;
               end
               for (i = 0; i < n; i++) begin
                  beat.elem_value = (r.op == OP_READ_FWD) ? cells[i] : cells[n - 1 - i];
                  beat.elem_valid = 1'b1;
                  beat.last       = (i == n - 1);
                  owed.push_back(beat);
               end
               return;
            end
            default: beat.found = 1'b0;
         endcase
         beat.entry_count = 6'(cells.size());
         owed.push_back(beat);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            failures++;
            $display("%0t: unexpected result beat value=%0d valid=%0b found=%0b count=%0d status=%0d last=%0b",
                     $time, got.elem_value, got.elem_valid, got.found, got.entry_count,
                     got.status, got.last);
            return;
         end
         want = owed.pop_front();
         if (got !== want) begin
            failures++;
            $display("%0t: mismatch expected value=%0d valid=%0b found=%0b count=%0d status=%0d last=%0b",
                     $time, want.elem_value, want.elem_valid, want.found, want.entry_count,
                     want.status, want.last);
            $display("%0t:          actual value=%0d valid=%0b found=%0b count=%0d status=%0d last=%0b",
                     $time, got.elem_value, got.elem_valid, got.found, got.entry_count,
                     got.status, got.last);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   list_scoreboard            book;
   logic signed [VALUE_W-1:0] pool[6];
   int unsigned               cycles;

   // Directed opening: empty-list corner cases first, then extremes, duplicates,
   // both readout directions, both removals and the unused selector.
   logic [2:0] dir_op[DIRECTED_N] = '{
      OP_READ_FWD, OP_READ_BWD, OP_REM_FIRST, OP_REM_ALL, OP_QUERY,
      OP_INS_BACK, OP_INS_FRONT, OP_INS_BACK, OP_INS_BACK, OP_INS_FRONT,
      OP_INS_BACK, OP_INS_FRONT, OP_QUERY, OP_QUERY, OP_READ_FWD,
      OP_READ_BWD, OP_REM_FIRST, OP_REM_ALL, OP_REM_FIRST, OP_SPARE,
      OP_SPARE, OP_READ_FWD, OP_REM_FIRST, OP_REM_ALL
   };
   logic signed [VALUE_W-1:0] dir_val[DIRECTED_N] = '{
      32'sh0000_0005, 32'sh0000_0005, 32'sh0000_0005, 32'sh0000_0005, 32'sh0000_0000,
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0007,
      32'sh0000_0007, 32'sh0000_0007, 32'sh0000_0007, 32'sh0000_007B, 32'sh1234_5678,
      32'shFFFF_FFFF, 32'sh0000_0007, 32'sh0000_0007, 32'sh0000_0007, 32'shA5A5_A5A5,
      32'sh5A5A_5A5A, 32'sh0000_0000, 32'sh8000_0000, 32'shFFFF_FFFF
   };

   // Round plan: two fills back to back push the list past full, drains
   // shrink it again with first-match and whole-value removals.
   mix_type plan[ROUNDS] = '{
      MIX_FILL, MIX_FILL, MIX_DRAIN, MIX_MIXED, MIX_DRAIN,
      MIX_FILL, MIX_FILL, MIX_MIXED, MIX_DRAIN, MIX_MIXED
   };

   ordered_value_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: give up well beyond the slowest legal run.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Monitor: check result beats before noting the request taken at the same
   // edge, since a result never belongs to a request accepted that cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) book.check_result(rsp_data);
         if (start && !busy) book.apply_request(req_data);
      end
   end

   // Present one request and hold it until the block takes it.
   task automatic send_beat(input logic [2:0] op, input logic signed [VALUE_W-1:0] v);
      req_type r;
      r.op    = op;
      r.value = v;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for a random burst now and then; scribble over the request
   // bus meanwhile to show it is ignored.
   task automatic maybe_idle(input logic allowed);
      req_type junk;
      if (allowed && $urandom_range(0, 5) == 0) begin
         junk.op    = 3'($urandom);
         junk.value = $urandom;
         start    <= 1'b0;
         req_data <= junk;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Hold off until every owed result beat has come back.
   task automatic drain_all();
      start <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   function automatic logic [2:0] pick_op(input mix_type mix);
      int unsigned roll;
      int unsigned cut[6];
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  cut = '{42, 84, 89, 93, 94, 98};
         MIX_DRAIN: cut = '{12, 24, 34, 64, 80, 95};
         default:   cut = '{18, 36, 50, 64, 72, 95};
      endcase
      if (roll < cut[0]) return OP_INS_FRONT;
      if (roll < cut[1]) return OP_INS_BACK;
      if (roll < cut[2]) return OP_QUERY;
      if (roll < cut[3]) return OP_REM_FIRST;
      if (roll < cut[4]) return OP_REM_ALL;
      if (roll < cut[5]) return ($urandom_range(0, 1) != 0) ? OP_READ_FWD : OP_READ_BWD;
      return OP_SPARE;
   endfunction

   // Mostly draw from a small pool so duplicates and hits are common; the rest
   // is full-width noise so every value bit toggles.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   initial begin
      int      n;
      int      round;
      int      sent;
      mix_type mix;
      book     = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      pool[0]  = 32'sh8000_0000;
      pool[1]  = 32'sh7FFF_FFFF;
      pool[2]  = 32'sh0000_0000;
      pool[3]  = 32'shFFFF_FFFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_N; n++) begin
         maybe_idle(1'b1);
         send_beat(dir_op[n], dir_val[n]);
      end
      drain_all();

      sent = 0;
      for (round = 0; round < ROUNDS; round++) begin
         // Let the block run dry at a couple of round boundaries.
         if (round == 3 || round == 7) drain_all();
         pool[4] = $urandom;
         pool[5] = $urandom;
         mix     = plan[round];
         for (n = 0; n < ROUND_LEN; n++) begin
            maybe_idle(sent < CALM_FROM);
            send_beat(pick_op(mix), pick_value());
            sent++;
         end
      end

      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.failures == 0 && book.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
